// ----- hw/rtl/pfb_pkg.sv -----
// Shared types and constants for the plane frame builder.
package pfb_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int WORD_WIDTH    = 32;
   localparam int Q_WIDTH       = FRACTION_BITS + 1;
   localparam int U_WIDTH       = FRACTION_BITS + 2;
   localparam int PROD_WIDTH    = WORD_WIDTH + U_WIDTH;

   localparam int SQ_STEPS      = 32;
   localparam int SQ_PER_STAGE  = 4;
   localparam int SQ_STAGES     = SQ_STEPS / SQ_PER_STAGE;

   localparam int DIV_STEPS     = FRACTION_BITS + 1;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

   localparam logic [63:0] W_ONE_WIDE = 64'd1 << FRACTION_BITS;
   localparam logic [16:0] W_ONE      = W_ONE_WIDE[16:0];

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [1:0] {
      COL_NORMAL,
      COL_TANGENT,
      COL_CROSS,
      COL_ORIGIN
   } column_type;

   typedef struct packed {
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         column_index;
      logic signed [31:0] col_x;
      logic signed [31:0] col_y;
      logic signed [31:0] col_z;
      logic [16:0]        col_w;
      logic               last_column;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] n;
      logic [2:0][31:0] p;
      axis_type         dom;
      axis_type         par;
      logic             neg_par;
      logic             neg_dom;
      logic             zero;
   } ctx_type;

endpackage

// ----- hw/rtl/plane_frame_builder.sv -----
// Top level: plane normal and origin in, four frame columns out.
//
//   channel | direction | beat
//   req_    | in        | one normal and origin per beat
//   rsp_    | out       | one frame column per beat, four per item
//
// An item may enter every cycle while the serialiser is empty; the four-beat
// column serialiser holds every stage until its last column is taken.
// There are 23 register stages before the serialiser: seven front stages,
// eight square-root stages (four root bits each), five divide stages and
// three for tangent, products and cross. Reset clears the valid bits and the
// column counter only. A stall on rsp_ freezes every stage.
module plane_frame_builder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfb_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfb_pkg::rsp_type  rsp_data
);
   import pfb_pkg::*;

   logic advance;

   // front stages
   logic             s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff;
   ctx_type          s0_ctx_ff, s1_ctx_ff, s2_ctx_ff, s3_ctx_ff, s4_ctx_ff, s5_ctx_ff;
   ctx_type          s6_ctx_ff;
   ctx_type          s0_ctx_in, s2_ctx_in;
   logic [2:0][31:0] s1_mag_ff, s1_mag_in;
   logic [31:0]      s2_a_ff, s2_b_ff, s2_big_ff, s2_a_in, s2_b_in;
   logic [31:0]      s3_a_ff, s3_b_ff, s3_big_ff, s3_a_in, s3_b_in, s3_big_in;
   logic [31:0]      s4_a_ff, s4_b_ff, s4_a_in, s4_b_in;
   logic [31:0]      s5_a_ff, s5_b_ff, s6_a_ff, s6_b_ff;
   logic [63:0]      s5_aa_ff, s5_bb_ff, s6_sum_ff;

   // square root
   logic        sq_v_ff   [SQ_STAGES];
   ctx_type     sq_ctx_ff [SQ_STAGES];
   logic [31:0] sq_a_ff   [SQ_STAGES];
   logic [31:0] sq_b_ff   [SQ_STAGES];
   logic [35:0] sq_rem_ff [SQ_STAGES];
   logic [35:0] sq_rem_in [SQ_STAGES];
   logic [31:0] sq_root_ff[SQ_STAGES];
   logic [31:0] sq_root_in[SQ_STAGES];
   logic [63:0] sq_rad_ff [SQ_STAGES];
   logic [63:0] sq_rad_in [SQ_STAGES];

   // division
   logic               dv_v_ff  [DIV_STAGES];
   ctx_type            dv_ctx_ff[DIV_STAGES];
   logic [31:0]        dv_s_ff  [DIV_STAGES];
   logic [32:0]        dv_ra_ff [DIV_STAGES];
   logic [32:0]        dv_ra_in [DIV_STAGES];
   logic [32:0]        dv_rb_ff [DIV_STAGES];
   logic [32:0]        dv_rb_in [DIV_STAGES];
   logic [Q_WIDTH-1:0] dv_qa_ff [DIV_STAGES];
   logic [Q_WIDTH-1:0] dv_qa_in [DIV_STAGES];
   logic [Q_WIDTH-1:0] dv_qb_ff [DIV_STAGES];
   logic [Q_WIDTH-1:0] dv_qb_in [DIV_STAGES];

   // tangent, products, cross
   logic                         u_v_ff, pr_v_ff, cr_v_ff;
   ctx_type                      u_ctx_ff, pr_ctx_ff, cr_ctx_ff;
   logic [2:0][U_WIDTH-1:0]      u_ff, u_in, pr_u_ff, cr_u_ff;
   logic [5:0][PROD_WIDTH-1:0]   pr_ff, pr_in;
   logic [2:0][31:0]             cr_ff, cr_in;

   // serialiser
   logic                    out_v_ff;
   column_type              out_cnt_ff;
   ctx_type                 out_ctx_ff;
   logic [2:0][U_WIDTH-1:0] out_u_ff;
   logic [2:0][31:0]        out_c_ff;

   assign advance   = !out_v_ff || (out_cnt_ff == COL_ORIGIN && !rsp_stall);
   assign req_stall = !advance;

   // stage 0 capture
   always_comb begin
      s0_ctx_in         = '0;
      s0_ctx_in.n[0]    = req_data.normal_x;
      s0_ctx_in.n[1]    = req_data.normal_y;
      s0_ctx_in.n[2]    = req_data.normal_z;
      s0_ctx_in.p[0]    = req_data.origin_x;
      s0_ctx_in.p[1]    = req_data.origin_y;
      s0_ctx_in.p[2]    = req_data.origin_z;
   end

   // magnitudes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_mag_in[i] = s0_ctx_ff.n[i][31] ? (~s0_ctx_ff.n[i] + 32'd1) : s0_ctx_ff.n[i];
      end
   end

   // dominant axis, partner and signs
   always_comb begin
      logic sgn_neg;
      s2_ctx_in = s1_ctx_ff;
      sgn_neg   = 1'b0;
      if (s1_mag_ff[0] >= s1_mag_ff[1]) begin
         s2_ctx_in.dom = (s1_mag_ff[0] >= s1_mag_ff[2]) ? AXIS_X : AXIS_Z;
      end else begin
         s2_ctx_in.dom = (s1_mag_ff[1] >= s1_mag_ff[2]) ? AXIS_Y : AXIS_Z;
      end
      case (s2_ctx_in.dom)
         AXIS_X: begin
            s2_ctx_in.par = AXIS_Y;
         end
         AXIS_Y: begin
            s2_ctx_in.par = AXIS_X;
            sgn_neg       = 1'b1;
         end
         default: begin
            s2_ctx_in.par = AXIS_Y;
            sgn_neg       = !s1_ctx_ff.n[2][31] && (s1_ctx_ff.n[2] != 32'd0);
         end
      endcase
      s2_a_in           = s1_mag_ff[s2_ctx_in.dom];
      s2_b_in           = s1_mag_ff[s2_ctx_in.par];
      s2_ctx_in.neg_par = s1_ctx_ff.n[s2_ctx_in.dom][31] ^ sgn_neg;
      s2_ctx_in.neg_dom = !(s1_ctx_ff.n[s2_ctx_in.par][31] ^ sgn_neg);
      s2_ctx_in.zero    = (s2_a_in | s2_b_in) == 32'd0;
   end

   // normalising shift, coarse then fine
   always_comb begin
      logic [31:0] a, b, big;
      a   = s2_a_ff;
      b   = s2_b_ff;
      big = s2_big_ff;
      if (big[31:15] == '0) begin
         a = a << 16; b = b << 16; big = big << 16;
      end
      if (big[31:23] == '0) begin
         a = a << 8; b = b << 8; big = big << 8;
      end
      s3_a_in   = a;
      s3_b_in   = b;
      s3_big_in = big;
   end

   always_comb begin
      logic [31:0] a, b, big;
      a   = s3_a_ff;
      b   = s3_b_ff;
      big = s3_big_ff;
      if (big[31:27] == '0) begin
         a = a << 4; b = b << 4; big = big << 4;
      end
      if (big[31:29] == '0) begin
         a = a << 2; b = b << 2; big = big << 2;
      end
      if (big[31:30] == '0) begin
         a = a << 1; b = b << 1;
      end
      s4_a_in = a;
      s4_b_in = b;
   end

   // square root, four root bits per stage
   always_comb begin
      logic [35:0] rem, rem2, trial;
      logic [31:0] root;
      logic [63:0] rad;
      for (int g = 0; g < SQ_STAGES; g++) begin
         if (g == 0) begin
            rem  = '0;
            root = '0;
            rad  = s6_sum_ff;
         end else begin
            rem  = sq_rem_ff[g-1];
            root = sq_root_ff[g-1];
            rad  = sq_rad_ff[g-1];
         end
         for (int k = 0; k < SQ_PER_STAGE; k++) begin
            rem2  = {rem[33:0], rad[63:62]};
            trial = {2'b00, root, 2'b01};
            if (rem2 >= trial) begin
               rem  = rem2 - trial;
               root = {root[30:0], 1'b1};
            end else begin
               rem  = rem2;
               root = {root[30:0], 1'b0};
            end
            rad = {rad[61:0], 2'b00};
         end
         sq_rem_in[g]  = rem;
         sq_root_in[g] = root;
         sq_rad_in[g]  = rad;
      end
   end

   // restoring division of both magnitudes by the root
   always_comb begin
      logic [32:0]        ra, rb, sw;
      logic [Q_WIDTH-1:0] qa, qb;
      logic               bit_a, bit_b;
      for (int g = 0; g < DIV_STAGES; g++) begin
         if (g == 0) begin
            sw = {1'b0, sq_root_ff[SQ_STAGES-1]};
            ra = {1'b0, sq_a_ff[SQ_STAGES-1]};
            rb = {1'b0, sq_b_ff[SQ_STAGES-1]};
            qa = '0;
            qb = '0;
         end else begin
            sw = {1'b0, dv_s_ff[g-1]};
            ra = dv_ra_ff[g-1];
            rb = dv_rb_ff[g-1];
            qa = dv_qa_ff[g-1];
            qb = dv_qb_ff[g-1];
         end
         for (int k = 0; k < DIV_PER_STAGE; k++) begin
            if (g * DIV_PER_STAGE + k < DIV_STEPS) begin
               bit_a = ra >= sw;
               bit_b = rb >= sw;
               if (bit_a) ra = ra - sw;
               if (bit_b) rb = rb - sw;
               qa = {qa[Q_WIDTH-2:0], bit_a};
               qb = {qb[Q_WIDTH-2:0], bit_b};
               ra = {ra[31:0], 1'b0};
               rb = {rb[31:0], 1'b0};
            end
         end
         dv_ra_in[g] = ra;
         dv_rb_in[g] = rb;
         dv_qa_in[g] = qa;
         dv_qb_in[g] = qb;
      end
   end

   // signed tangent
   always_comb begin
      logic signed [U_WIDTH-1:0] ua, ub;
      ctx_type                   c;
      c    = dv_ctx_ff[DIV_STAGES-1];
      ua   = $signed({1'b0, dv_qa_ff[DIV_STAGES-1]});
      ub   = $signed({1'b0, dv_qb_ff[DIV_STAGES-1]});
      u_in = '0;
      if (!c.zero) begin
         u_in[c.par] = c.neg_par ? -ua : ua;
         u_in[c.dom] = c.neg_dom ? -ub : ub;
      end
   end

   // products for normal cross tangent
   always_comb begin
      pr_in[0] = PROD_WIDTH'($signed(u_ctx_ff.n[1]) * $signed(u_ff[2]));
      pr_in[1] = PROD_WIDTH'($signed(u_ctx_ff.n[2]) * $signed(u_ff[1]));
      pr_in[2] = PROD_WIDTH'($signed(u_ctx_ff.n[2]) * $signed(u_ff[0]));
      pr_in[3] = PROD_WIDTH'($signed(u_ctx_ff.n[0]) * $signed(u_ff[2]));
      pr_in[4] = PROD_WIDTH'($signed(u_ctx_ff.n[0]) * $signed(u_ff[1]));
      pr_in[5] = PROD_WIDTH'($signed(u_ctx_ff.n[1]) * $signed(u_ff[0]));
   end

   // difference, floor shift, wrap
   always_comb begin
      logic signed [PROD_WIDTH:0] diff;
      for (int i = 0; i < 3; i++) begin
         diff     = (PROD_WIDTH + 1)'($signed(pr_ff[2*i]))
                  - (PROD_WIDTH + 1)'($signed(pr_ff[2*i+1]));
         cr_in[i] = diff[FRACTION_BITS+31:FRACTION_BITS];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         for (int g = 0; g < SQ_STAGES; g++) sq_v_ff[g] <= 1'b0;
         for (int g = 0; g < DIV_STAGES; g++) dv_v_ff[g] <= 1'b0;
         u_v_ff   <= 1'b0;
         pr_v_ff  <= 1'b0;
         cr_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         out_cnt_ff <= COL_NORMAL;
      end else if (advance) begin
         s0_v_ff  <= req_valid;
         s1_v_ff  <= s0_v_ff;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         s6_v_ff  <= s5_v_ff;
         sq_v_ff[0] <= s6_v_ff;
         for (int g = 1; g < SQ_STAGES; g++) sq_v_ff[g] <= sq_v_ff[g-1];
         dv_v_ff[0] <= sq_v_ff[SQ_STAGES-1];
         for (int g = 1; g < DIV_STAGES; g++) dv_v_ff[g] <= dv_v_ff[g-1];
         u_v_ff   <= dv_v_ff[DIV_STAGES-1];
         pr_v_ff  <= u_v_ff;
         cr_v_ff  <= pr_v_ff;
         out_v_ff <= cr_v_ff;
         out_cnt_ff <= COL_NORMAL;
      end else if (out_v_ff && !rsp_stall) begin
         out_cnt_ff <= column_type'(2'(out_cnt_ff + 2'd1));
      end
   end

   // payload: hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ctx_ff <= s0_ctx_in;
         s1_ctx_ff <= s0_ctx_ff;
         s1_mag_ff <= s1_mag_in;
         s2_ctx_ff <= s2_ctx_in;
         s2_a_ff   <= s2_a_in;
         s2_b_ff   <= s2_b_in;
         s2_big_ff <= (s2_a_in > s2_b_in) ? s2_a_in : s2_b_in;
         s3_ctx_ff <= s2_ctx_ff;
         s3_a_ff   <= s3_a_in;
         s3_b_ff   <= s3_b_in;
         s3_big_ff <= s3_big_in;
         s4_ctx_ff <= s3_ctx_ff;
         s4_a_ff   <= s4_a_in;
         s4_b_ff   <= s4_b_in;
         s5_ctx_ff <= s4_ctx_ff;
         s5_a_ff   <= s4_a_ff;
         s5_b_ff   <= s4_b_ff;
         s5_aa_ff  <= s4_a_ff * s4_a_ff;
         s5_bb_ff  <= s4_b_ff * s4_b_ff;
         s6_ctx_ff <= s5_ctx_ff;
         s6_a_ff   <= s5_a_ff;
         s6_b_ff   <= s5_b_ff;
         s6_sum_ff <= s5_aa_ff + s5_bb_ff;
         for (int g = 0; g < SQ_STAGES; g++) begin
            sq_ctx_ff[g]  <= (g == 0) ? s6_ctx_ff : sq_ctx_ff[g-1];
            sq_a_ff[g]    <= (g == 0) ? s6_a_ff : sq_a_ff[g-1];
            sq_b_ff[g]    <= (g == 0) ? s6_b_ff : sq_b_ff[g-1];
            sq_rem_ff[g]  <= sq_rem_in[g];
            sq_root_ff[g] <= sq_root_in[g];
            sq_rad_ff[g]  <= sq_rad_in[g];
         end
         for (int g = 0; g < DIV_STAGES; g++) begin
            dv_ctx_ff[g] <= (g == 0) ? sq_ctx_ff[SQ_STAGES-1] : dv_ctx_ff[g-1];
            dv_s_ff[g]   <= (g == 0) ? sq_root_ff[SQ_STAGES-1] : dv_s_ff[g-1];
            dv_ra_ff[g]  <= dv_ra_in[g];
            dv_rb_ff[g]  <= dv_rb_in[g];
            dv_qa_ff[g]  <= dv_qa_in[g];
            dv_qb_ff[g]  <= dv_qb_in[g];
         end
         u_ctx_ff   <= dv_ctx_ff[DIV_STAGES-1];
         u_ff       <= u_in;
         pr_ctx_ff  <= u_ctx_ff;
         pr_u_ff    <= u_ff;
         pr_ff      <= pr_in;
         cr_ctx_ff  <= pr_ctx_ff;
         cr_u_ff    <= pr_u_ff;
         cr_ff      <= cr_in;
         out_ctx_ff <= cr_ctx_ff;
         out_u_ff   <= cr_u_ff;
         out_c_ff   <= cr_ff;
      end
   end

   // column select
   assign rsp_valid = out_v_ff;

   always_comb begin
      rsp_data              = '0;
      rsp_data.column_index = out_cnt_ff;
      case (out_cnt_ff)
         COL_NORMAL: begin
            rsp_data.col_x = out_ctx_ff.n[0];
            rsp_data.col_y = out_ctx_ff.n[1];
            rsp_data.col_z = out_ctx_ff.n[2];
         end
         COL_TANGENT: begin
            rsp_data.col_x = 32'($signed(out_u_ff[0]));
            rsp_data.col_y = 32'($signed(out_u_ff[1]));
            rsp_data.col_z = 32'($signed(out_u_ff[2]));
         end
         COL_CROSS: begin
            rsp_data.col_x = out_c_ff[0];
            rsp_data.col_y = out_c_ff[1];
            rsp_data.col_z = out_c_ff[2];
         end
         default: begin
            rsp_data.col_x       = out_ctx_ff.p[0];
            rsp_data.col_y       = out_ctx_ff.p[1];
            rsp_data.col_z       = out_ctx_ff.p[2];
            rsp_data.col_w       = W_ONE;
            rsp_data.last_column = 1'b1;
         end
      endcase
   end

endmodule
